@@ rtl/core/bal_pkg.sv @@
// Shared types and codes for the bounded array list.
// Used by bal_ctrl, bal_dp, bounded_array_list, bal_result_checker and the testbench; depends on nothing.
`timescale 1ns / 1ps

package bal_pkg;

    // Operation codes
    localparam logic [2:0] OP_APPEND     = 3'd0;
    localparam logic [2:0] OP_PUSH_FRONT = 3'd1;
    localparam logic [2:0] OP_POP_END    = 3'd2;
    localparam logic [2:0] OP_POP_FRONT  = 3'd3;
    localparam logic [2:0] OP_READ       = 3'd4;
    localparam logic [2:0] OP_WRITE      = 3'd5;

    // Result status codes
    localparam logic [1:0] STAT_OK   = 2'd0;
    localparam logic [1:0] STAT_BAD  = 2'd1;
    localparam logic [1:0] STAT_FULL = 2'd2;

    // Beat widths
    localparam int OPCODE_W   = 3;
    localparam int POSITION_W = 4;
    localparam int VALUE_W    = 32;
    localparam int STATUS_W   = 2;
    localparam int FILL_W     = 5;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 40;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_LOAD
    } t_state;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic capture;
        logic exec;
        logic load;
    } t_cmd;

endpackage

@@ rtl/core/bal_ctrl.sv @@
// Sequencer for the bounded array list: steps each beat through capture,
// execute and result load. Depends on bal_pkg.
`timescale 1ns / 1ps

module bal_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output bal_pkg::t_cmd o_cmd
);

    bal_pkg::t_state r_state;
    bal_pkg::t_state n_state;
    logic            r_out_valid;
    logic            n_out_valid;
    logic            slot_free;

    assign slot_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            bal_pkg::ST_IDLE: begin
                if (i_in_valid) n_state = bal_pkg::ST_EXEC;
            end
            bal_pkg::ST_EXEC: begin
                n_state = bal_pkg::ST_LOAD;
            end
            bal_pkg::ST_LOAD: begin
                if (slot_free) n_state = bal_pkg::ST_IDLE;
            end
            default: begin
                n_state = bal_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready    = 1'b0;
        o_cmd.capture = 1'b0;
        o_cmd.exec    = 1'b0;
        o_cmd.load    = 1'b0;
        case (r_state)
            bal_pkg::ST_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.capture = i_in_valid;
            end
            bal_pkg::ST_EXEC: begin
                o_cmd.exec = 1'b1;
            end
            bal_pkg::ST_LOAD: begin
                o_cmd.load = slot_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    // Hold the result until taken; a fresh load overrides the drain
    always_comb begin
        n_out_valid = r_out_valid;
        if (i_out_ready) n_out_valid = 1'b0;
        if (o_cmd.load)  n_out_valid = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bal_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

@@ rtl/core/bal_dp.sv @@
// Datapath for the bounded array list: circular word store with head
// pointer and fill count, one adder for addressing, result register.
// Depends on bal_pkg.
`timescale 1ns / 1ps

module bal_dp #(
    parameter int LIST_DEPTH = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  bal_pkg::t_cmd                       i_cmd,
    input  logic [bal_pkg::IN_TDATA_W-1:0]      i_tdata,
    output logic [bal_pkg::OUT_TDATA_W-1:0]     o_tdata
);

    localparam int AW   = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CW   = $clog2(LIST_DEPTH + 1);
    localparam int CMPW = (CW > bal_pkg::POSITION_W) ? CW : bal_pkg::POSITION_W;
    localparam int FXW  = (CW > bal_pkg::FILL_W) ? CW : bal_pkg::FILL_W;

    logic [bal_pkg::VALUE_W-1:0]    r_mem [LIST_DEPTH];

    logic [bal_pkg::OPCODE_W-1:0]   r_op;
    logic [bal_pkg::POSITION_W-1:0] r_pos;
    logic [bal_pkg::VALUE_W-1:0]    r_val;
    logic [AW-1:0]                  r_head;
    logic [AW-1:0]                  n_head;
    logic [CW-1:0]                  r_fill;
    logic [CW-1:0]                  n_fill;
    logic [bal_pkg::VALUE_W-1:0]    r_rd_data;
    logic [bal_pkg::STATUS_W-1:0]   r_status;
    logic [bal_pkg::STATUS_W-1:0]   n_status;
    logic                           r_use_rd;
    logic                           n_use_rd;
    logic [bal_pkg::OUT_TDATA_W-1:0] r_out;

    logic                 full;
    logic                 empty;
    logic                 pos_ok;
    logic [CMPW-1:0]      pos_ext;
    logic [CMPW-1:0]      fill_cmp;
    logic [CW-1:0]        fill_m1;
    logic [AW-1:0]        off;
    logic [AW:0]          sum;
    logic [AW:0]          sum_wrap;
    logic [AW-1:0]        addr;
    logic [AW-1:0]        head_dec;
    logic [AW-1:0]        head_inc;
    logic                 we;
    logic [AW-1:0]        wr_addr;
    logic [FXW-1:0]       fill_out;
    logic [bal_pkg::VALUE_W-1:0] value_out;

    assign full     = (r_fill == CW'(LIST_DEPTH));
    assign empty    = (r_fill == '0);
    assign pos_ext  = CMPW'(r_pos);
    assign fill_cmp = CMPW'(r_fill);
    assign pos_ok   = (pos_ext < fill_cmp);
    assign fill_m1  = r_fill - CW'(1);

    assign head_dec = (r_head == '0) ? AW'(LIST_DEPTH - 1) : r_head - AW'(1);
    assign head_inc = (r_head == AW'(LIST_DEPTH - 1)) ? '0 : r_head + AW'(1);

    // Entry offset from the head, by operation
    always_comb begin
        case (r_op)
            bal_pkg::OP_APPEND:  off = r_fill[AW-1:0];
            bal_pkg::OP_POP_END: off = fill_m1[AW-1:0];
            bal_pkg::OP_READ,
            bal_pkg::OP_WRITE:   off = pos_ext[AW-1:0];
            default:             off = '0;
        endcase
    end

    // Wrap head + offset into the store
    assign sum      = {1'b0, r_head} + {1'b0, off};
    assign sum_wrap = (sum >= (AW + 1)'(LIST_DEPTH)) ? sum - (AW + 1)'(LIST_DEPTH) : sum;
    assign addr     = sum_wrap[AW-1:0];

    always_comb begin
        n_head   = r_head;
        n_fill   = r_fill;
        n_status = bal_pkg::STAT_OK;
        n_use_rd = 1'b0;
        we       = 1'b0;
        wr_addr  = addr;
        case (r_op)
            bal_pkg::OP_APPEND: begin
                if (full) begin
                    n_status = bal_pkg::STAT_FULL;
                end else begin
                    we     = 1'b1;
                    n_fill = r_fill + CW'(1);
                end
            end
            bal_pkg::OP_PUSH_FRONT: begin
                if (full) begin
                    n_status = bal_pkg::STAT_FULL;
                end else begin
                    we      = 1'b1;
                    wr_addr = head_dec;
                    n_head  = head_dec;
                    n_fill  = r_fill + CW'(1);
                end
            end
            bal_pkg::OP_POP_END: begin
                if (empty) begin
                    n_status = bal_pkg::STAT_BAD;
                end else begin
                    n_use_rd = 1'b1;
                    n_fill   = fill_m1;
                end
            end
            bal_pkg::OP_POP_FRONT: begin
                if (empty) begin
                    n_status = bal_pkg::STAT_BAD;
                end else begin
                    n_use_rd = 1'b1;
                    n_head   = head_inc;
                    n_fill   = fill_m1;
                end
            end
            bal_pkg::OP_READ: begin
                if (pos_ok) n_use_rd = 1'b1;
                else        n_status = bal_pkg::STAT_BAD;
            end
            bal_pkg::OP_WRITE: begin
                if (pos_ok) we = 1'b1;
                else        n_status = bal_pkg::STAT_BAD;
            end
            default: begin
                n_status = bal_pkg::STAT_BAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_fill <= '0;
        end else if (i_cmd.exec) begin
            r_head <= n_head;
            r_fill <= n_fill;
        end
    end

    // Store: one write and one registered read per beat
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && we) r_mem[wr_addr] <= r_val;
        if (i_cmd.exec)       r_rd_data     <= r_mem[addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op  <= i_tdata[2:0];
            r_pos <= i_tdata[6:3];
            r_val <= i_tdata[38:7];
        end
        if (i_cmd.exec) begin
            r_status <= n_status;
            r_use_rd <= n_use_rd;
        end
        if (i_cmd.load) r_out <= {1'b0, fill_out[4:0], r_status, value_out};
    end

    assign fill_out  = FXW'(r_fill);
    assign value_out = r_use_rd ? r_rd_data : '0;
    assign o_tdata   = r_out;

endmodule

@@ rtl/core/bounded_array_list.sv @@
// Bounded array list: fixed-depth deque of signed 32-bit words.
// Each beat steps through capture, execute with the store's registered read, and
// result load; the result beat is then valid. One beat is in flight at a time, and the
// load waits for a free output slot; input is taken while a result waits.
// Reset clears the fill count, head pointer and output valid; store contents stay.
`timescale 1ns / 1ps

module bounded_array_list #(
    parameter int LIST_DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [2:0] opcode, [6:3] position, [38:7] value_in, [39] zero
    input  logic [39:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [31:0] value_out, [33:32] status, [38:34] fill_level, [39] zero
    output logic [39:0] m_axis_tdata
);

    bal_pkg::t_cmd cmd;

    bal_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_cmd       (cmd)
    );

    bal_dp #(
        .LIST_DEPTH (LIST_DEPTH)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_tdata (s_axis_tdata),
        .o_tdata (m_axis_tdata)
    );

    // One beat in flight: no second accept straight after the first
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input accepted while a beat is in flight");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[33:32] != 2'd3))
        else $error("undefined status code");

    // Refused operations return zero
    a_refused_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tdata[33:32] != bal_pkg::STAT_OK))
            |-> (m_axis_tdata[31:0] == 32'd0))
        else $error("refused operation returned data");

endmodule

@@ dv/bal_result_checker.sv @@
// Result checker for the bounded array list: mirrors the list contents and fill level,
// predicts one reply per accepted operation beat and compares the returned beats in order.
// Depends on bal_pkg for the operation and status codes.
`timescale 1ns / 1ps

module bal_result_checker #(
    parameter int DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_op_valid,
    input  logic        i_op_ready,
    // [2:0] opcode, [6:3] position, [38:7] value_in, [39] zero
    input  logic [39:0] i_op_data,
    input  logic        i_reply_valid,
    input  logic        i_reply_ready,
    // [31:0] value_out, [33:32] status, [38:34] fill_level, [39] zero
    input  logic [39:0] i_reply_data,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_checked
);

    typedef struct packed {
        logic [31:0] word;
        logic [1:0]  status;
        logic [4:0]  fill;
    } t_list_reply;

    logic [31:0]  list_words [0:DEPTH-1];
    int           list_fill;
    t_list_reply  expected_replies [$];
    int           fails;
    int           checked;

    initial begin
        list_fill    = 0;
        fails        = 0;
        checked      = 0;
        o_fail_count = 0;
        o_pending    = 0;
        o_checked    = 0;
    end

    task automatic apply_list_op(input logic [2:0] op, input logic [3:0] pos,
                                 input logic [31:0] word, output t_list_reply rep);
        int k;
        rep.word   = '0;
        rep.status = bal_pkg::STAT_OK;
        case (op)
            bal_pkg::OP_APPEND, bal_pkg::OP_PUSH_FRONT: begin
                if (list_fill >= DEPTH) begin
                    rep.status = bal_pkg::STAT_FULL;
                end else begin
                    if (op == bal_pkg::OP_APPEND) begin
                        list_words[list_fill] = word;
                    end else begin
                        for (k = list_fill; k > 0; k--)
                            list_words[k] = list_words[k-1];
                        list_words[0] = word;
                    end
                    list_fill++;
                end
            end
            bal_pkg::OP_POP_END: begin
                if (list_fill == 0) begin
                    rep.status = bal_pkg::STAT_BAD;
                end else begin
                    list_fill--;
                    rep.word = list_words[list_fill];
                end
            end
            bal_pkg::OP_POP_FRONT: begin
                if (list_fill == 0) begin
                    rep.status = bal_pkg::STAT_BAD;
                end else begin
                    rep.word = list_words[0];
                    for (k = 0; k + 1 < list_fill; k++)
                        list_words[k] = list_words[k+1];
                    list_fill--;
                end
            end
            bal_pkg::OP_READ, bal_pkg::OP_WRITE: begin
                if (int'(pos) >= list_fill) begin
                    rep.status = bal_pkg::STAT_BAD;
                end else if (op == bal_pkg::OP_READ) begin
                    rep.word = list_words[pos];
                end else begin
                    list_words[pos] = word;
                end
            end
            default: begin
                rep.status = bal_pkg::STAT_BAD;
            end
        endcase
        rep.fill = list_fill[4:0];
    endtask

    always @(posedge i_clk) begin
        t_list_reply want;
        t_list_reply got;
        if (!i_rst_n) begin
            list_fill = 0;
            expected_replies.delete();
        end else begin
            if (i_reply_valid && i_reply_ready) begin
                got.word   = i_reply_data[31:0];
                got.status = i_reply_data[33:32];
                got.fill   = i_reply_data[38:34];
                if (expected_replies.size() == 0) begin
                    $error("reply beat with no operation outstanding: data %h", i_reply_data);
                    fails++;
                end else begin
                    want = expected_replies.pop_front();
                    checked++;
                    if (got.word !== want.word) begin
                        $error("value_out: expected %0d, got %0d",
                               $signed(want.word), $signed(got.word));
                        fails++;
                    end
                    if (got.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, got.status);
                        fails++;
                    end
                    if (got.fill !== want.fill) begin
                        $error("fill_level: expected %0d, got %0d", want.fill, got.fill);
                        fails++;
                    end
                end
            end
            if (i_op_valid && i_op_ready) begin
                apply_list_op(i_op_data[2:0], i_op_data[6:3], i_op_data[38:7], want);
                expected_replies.push_back(want);
            end
        end
        o_fail_count <= fails;
        o_pending    <= expected_replies.size();
        o_checked    <= checked;
    end

endmodule

@@ dv/tb_bounded_array_list.sv @@
// Testbench top for bounded_array_list: drives operation beats with random gaps and
// result back-pressure, and takes the verdict from bal_result_checker.
// Depends on bal_pkg, bounded_array_list and bal_result_checker.
`timescale 1ns / 1ps

module tb_bounded_array_list;

    localparam int          DEPTH        = 16;
    localparam int          RANDOM_OPS   = 950;
    localparam int          PHASE_LEN    = 40;
    localparam int          CYCLE_LIMIT  = 250000;
    localparam logic [2:0]  OP_SPARE_LO  = 3'd6;
    localparam logic [2:0]  OP_SPARE_HI  = 3'd7;

    typedef enum logic [1:0] {
        MODE_GROW,
        MODE_SHRINK,
        MODE_MIXED,
        MODE_NOISE
    } t_mode;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;

    int          fail_count;
    int          pending;
    int          checked;
    int          ops_sent = 0;
    int          cycle_count = 0;
    logic        calm = 1'b0;

    always #1 i_clk = ~i_clk;

    bounded_array_list #(
        .LIST_DEPTH(DEPTH)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    bal_result_checker #(
        .DEPTH(DEPTH)
    ) u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_op_valid    (s_axis_tvalid),
        .i_op_ready    (s_axis_tready),
        .i_op_data     (s_axis_tdata),
        .i_reply_valid (m_axis_tvalid),
        .i_reply_ready (m_axis_tready),
        .i_reply_data  (m_axis_tdata),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_checked     (checked)
    );

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Run stopped at the cycle limit with %0d replies outstanding", pending);
            $display("TB_ERROR");
            $finish;
        end
    end

    // Hold an operation beat until the list takes it; optionally idle first.
    task automatic send_op(input logic [2:0] op, input logic [3:0] pos,
                           input logic [31:0] word);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 8);
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, word, pos, op};
        do @(posedge i_clk); while (!s_axis_tready);
        ops_sent++;
    endtask

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 11))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'hFFFF_FFFF;
            3:       return 32'h0000_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [2:0] pick_push();
        return $urandom_range(0, 1) ? bal_pkg::OP_APPEND : bal_pkg::OP_PUSH_FRONT;
    endfunction

    function automatic logic [2:0] pick_pop();
        return $urandom_range(0, 1) ? bal_pkg::OP_POP_END : bal_pkg::OP_POP_FRONT;
    endfunction

    function automatic logic [2:0] pick_access();
        return $urandom_range(0, 1) ? bal_pkg::OP_READ : bal_pkg::OP_WRITE;
    endfunction

    function automatic logic [2:0] pick_op(input t_mode mode);
        int r;
        r = $urandom_range(0, 9);
        case (mode)
            MODE_GROW:   return (r < 6) ? pick_push() : (r == 6) ? pick_pop() : pick_access();
            MODE_SHRINK: return (r < 6) ? pick_pop() : (r == 6) ? pick_push() : pick_access();
            MODE_MIXED:  return 3'($urandom_range(0, 5));
            default:     return 3'($urandom_range(0, 7));
        endcase
    endfunction

    // Return path: stall for a random number of cycles, then take one reply beat.
    initial begin
        int stall;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            stall = calm ? 0 : $urandom_range(0, 8);
            if (stall != 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
        end
    end

    initial begin
        t_mode mode;
        int    k;
        logic [3:0] pos;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Empty list: removals and a write are refused, spare opcodes are refused and change nothing.
        send_op(bal_pkg::OP_POP_END, 4'd0, 32'h1234_5678);
        send_op(bal_pkg::OP_POP_FRONT, 4'd15, 32'h8765_4321);
        send_op(bal_pkg::OP_WRITE, 4'd0, 32'hFFFF_FFFF);
        send_op(OP_SPARE_LO, 4'd9, 32'h8000_0000);
        send_op(OP_SPARE_HI, 4'd6, 32'h7FFF_FFFF);

        // Fill to the brim from both ends with the word extremes first.
        for (k = 0; k < DEPTH; k++) begin
            send_op(k[0] ? bal_pkg::OP_PUSH_FRONT : bal_pkg::OP_APPEND,
                    4'($urandom_range(0, 15)),
                    (k == 0) ? 32'h7FFF_FFFF : (k == 1) ? 32'h8000_0000 :
                    (k == 2) ? 32'hFFFF_FFFF : (k == 3) ? 32'h0000_0000 : $urandom);
        end

        // Full list: both inserts refused, last position still readable; after a front pop it is refused.
        send_op(bal_pkg::OP_APPEND, 4'd0, 32'hDEAD_BEEF);
        send_op(bal_pkg::OP_PUSH_FRONT, 4'd0, 32'hCAFE_F00D);
        send_op(bal_pkg::OP_READ, 4'd15, 32'h0);
        send_op(bal_pkg::OP_POP_FRONT, 4'd0, 32'h0);
        send_op(bal_pkg::OP_READ, 4'd15, 32'h0);

        for (k = 0; k < RANDOM_OPS; k++) begin
            if (k % PHASE_LEN == 0) begin
                mode = t_mode'($urandom_range(0, 3));
                calm = ($urandom_range(0, 3) == 0);
            end
            // favour low positions so that accesses often land inside a short list
            pos = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
                                              : 4'($urandom_range(0, 7));
            send_op(pick_op(mode), pos, pick_word());
        end
        s_axis_tvalid <= 1'b0;
        calm = 1'b0;

        // let the checker count the last beat before watching the outstanding total
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);

        $display("Covered %0d operation beats: every opcode, empty and full list, extreme words,",
                 ops_sent);
        $display("random idling on both sides; %0d replies compared, %0d left unanswered",
                 checked, pending);
        if (fail_count == 0 && pending == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/core/bal_pkg.sv
rtl/core/bal_ctrl.sv
rtl/core/bal_dp.sv
rtl/core/bounded_array_list.sv
dv/bal_result_checker.sv
dv/tb_bounded_array_list.sv
